// ----- sv/psab_pkg.sv -----
// Package: shared types, constants and command/status structs for the accumulation buffer.
package psab_pkg;

  localparam int MaxWidth   = 256;
  localparam int MaxHeight  = 256;
  localparam int CountBits  = 24;
  localparam int SumBits    = 40;
  localparam int MeanBits   = 24;
  localparam int XBits      = 8;
  localparam int YBits      = 8;
  localparam int AddrBits   = XBits + YBits;
  localparam int DivCntBits = 6;

  localparam logic [SumBits-1:0]   SumMax    = {SumBits{1'b1}};
  localparam logic [SumBits-1:0]   SampleMax = SumBits'(24'hFFFFFF);
  localparam logic [MeanBits-1:0]  MeanMax   = {MeanBits{1'b1}};
  localparam logic [CountBits-1:0] CountMax  = {CountBits{1'b1}};

  typedef enum logic [1:0] {
    OP_ACCUM   = 2'd0,
    OP_MERGE   = 2'd1,
    OP_DEVELOP = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_EXEC,
    S_DIV,
    S_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item
    logic sweep_en;  // write zero at sweep address
    logic sweep_rst; // restart sweep counter
    logic rd_en;     // read store at item address
    logic wr_en;     // write updated entry
    logic div_start;
    logic div_step;
    logic out_load;  // capture result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       in_range;
    logic       sweep_done;
    logic       cnt_zero;
    logic       div_done;
  } sts_t;

endpackage

// ----- sv/psab_ctrl.sv -----
// Controller: sequences clear sweep, read-modify-write, division and result handoff.
module psab_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_busy_i,
  output psab_pkg::cmd_t cmd_o,
  input  psab_pkg::sts_t sts_i
);
  import psab_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_INIT;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep_en = 1'b1;
        if (sts_i.sweep_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        if (sts_i.op == OP_CLEAR) begin
          cmd_o.sweep_rst = 1'b1;
          state_d         = S_INIT;
          // clear's result is registered here, the sweep follows
          if (!out_busy_i) begin
            cmd_o.out_load = 1'b1;
          end else begin
            state_d = S_READ;
            cmd_o.sweep_rst = 1'b0;
          end
        end else if (!sts_i.in_range) begin
          state_d = S_OUT;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.op == OP_DEVELOP) begin
          if (sts_i.cnt_zero) begin
            state_d = S_OUT;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end
        end else begin
          cmd_o.wr_en = 1'b1;
          state_d     = S_OUT;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_busy_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

endmodule

// ----- sv/psab_dp.sv -----
// Datapath: pixel store, saturating adders, restoring divider and result register.
module psab_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  psab_pkg::cmd_t                    cmd_i,
  output psab_pkg::sts_t                    sts_o,
  input  logic [8:0]                        width_i,
  input  logic [8:0]                        height_i,
  input  logic [1:0]                        op_i,
  input  logic [psab_pkg::XBits-1:0]        x_i,
  input  logic [psab_pkg::YBits-1:0]        y_i,
  input  logic [psab_pkg::SumBits-1:0]      red_i,
  input  logic [psab_pkg::SumBits-1:0]      green_i,
  input  logic [psab_pkg::SumBits-1:0]      blue_i,
  input  logic [psab_pkg::CountBits-1:0]    cnt_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [psab_pkg::MeanBits-1:0]     red_o,
  output logic [psab_pkg::MeanBits-1:0]     green_o,
  output logic [psab_pkg::MeanBits-1:0]     blue_o,
  output logic [1:0]                        status_o
);
  import psab_pkg::*;

  localparam int NumPix = MaxWidth * MaxHeight;
  localparam int EntBits = 3 * SumBits + CountBits;

  logic [EntBits-1:0] mem_q [NumPix];

  logic [1:0]             op_q;
  logic [XBits-1:0]       x_q;
  logic [YBits-1:0]       y_q;
  logic [SumBits-1:0]     rv_q, gv_q, bv_q;
  logic [CountBits-1:0]   ac_q;
  logic [AddrBits:0]      swp_q;
  logic [EntBits-1:0]     rd_q;
  logic [AddrBits-1:0]    addr;
  logic [8:0]             wlim, hlim;
  logic                   in_range;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i; x_q <= x_i; y_q <= y_i;
      rv_q <= red_i; gv_q <= green_i; bv_q <= blue_i; ac_q <= cnt_i;
    end
  end

  assign wlim     = (width_i > 9'(MaxWidth)) ? 9'(MaxWidth) : width_i;
  assign hlim     = (height_i > 9'(MaxHeight)) ? 9'(MaxHeight) : height_i;
  assign in_range = ({1'b0, x_q} < wlim) && ({1'b0, y_q} < hlim);
  assign addr     = {y_q, x_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)              swp_q <= '0;
    else if (cmd_i.sweep_rst) swp_q <= '0;
    else if (cmd_i.sweep_en && !swp_q[AddrBits]) swp_q <= swp_q + 1'b1;
  end

  // saturating update of the read entry
  logic [SumBits-1:0]   r_old, g_old, b_old, r_add, g_add, b_add;
  logic [CountBits-1:0] c_old, c_add;
  logic [SumBits:0]     r_s, g_s, b_s;
  logic [CountBits:0]   c_s;
  logic [EntBits-1:0]   wdata;

  assign {r_old, g_old, b_old, c_old} = rd_q;

  always_comb begin
    if (op_q == OP_ACCUM) begin
      r_add = (rv_q > SampleMax) ? SampleMax : rv_q;
      g_add = (gv_q > SampleMax) ? SampleMax : gv_q;
      b_add = (bv_q > SampleMax) ? SampleMax : bv_q;
      c_add = CountBits'(1);
    end else begin
      r_add = rv_q; g_add = gv_q; b_add = bv_q; c_add = ac_q;
    end
    r_s = {1'b0, r_old} + {1'b0, r_add};
    g_s = {1'b0, g_old} + {1'b0, g_add};
    b_s = {1'b0, b_old} + {1'b0, b_add};
    c_s = {1'b0, c_old} + {1'b0, c_add};
    wdata = {r_s[SumBits] ? SumMax : r_s[SumBits-1:0],
             g_s[SumBits] ? SumMax : g_s[SumBits-1:0],
             b_s[SumBits] ? SumMax : b_s[SumBits-1:0],
             c_s[CountBits] ? CountMax : c_s[CountBits-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_en && !swp_q[AddrBits]) mem_q[swp_q[AddrBits-1:0]] <= '0;
    else if (cmd_i.wr_en)                   mem_q[addr] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) rd_q <= mem_q[addr];
  end

  // three restoring dividers sharing one count, one quotient bit a cycle
  logic [DivCntBits-1:0]  dcnt_q;
  logic [SumBits-1:0]     rq_q, gq_q, bq_q;
  logic [CountBits:0]     rr_q, gr_q, br_q;
  logic [CountBits:0]     rt, gt, bt;

  assign rt = {rr_q[CountBits-1:0], rq_q[SumBits-1]};
  assign gt = {gr_q[CountBits-1:0], gq_q[SumBits-1]};
  assign bt = {br_q[CountBits-1:0], bq_q[SumBits-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= DivCntBits'(SumBits);
    end else if (cmd_i.div_step && dcnt_q != '0) begin
      dcnt_q <= dcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rq_q <= r_old; gq_q <= g_old; bq_q <= b_old;
      rr_q <= '0; gr_q <= '0; br_q <= '0;
    end else if (cmd_i.div_step && dcnt_q != '0) begin
      if (rt >= {1'b0, c_old}) begin
        rr_q <= rt - {1'b0, c_old}; rq_q <= {rq_q[SumBits-2:0], 1'b1};
      end else begin
        rr_q <= rt; rq_q <= {rq_q[SumBits-2:0], 1'b0};
      end
      if (gt >= {1'b0, c_old}) begin
        gr_q <= gt - {1'b0, c_old}; gq_q <= {gq_q[SumBits-2:0], 1'b1};
      end else begin
        gr_q <= gt; gq_q <= {gq_q[SumBits-2:0], 1'b0};
      end
      if (bt >= {1'b0, c_old}) begin
        br_q <= bt - {1'b0, c_old}; bq_q <= {bq_q[SumBits-2:0], 1'b1};
      end else begin
        br_q <= bt; bq_q <= {bq_q[SumBits-2:0], 1'b0};
      end
    end
  end

  function automatic logic [MeanBits-1:0] sat_mean(input logic [SumBits-1:0] q);
    sat_mean = (q[SumBits-1:MeanBits] != '0) ? MeanMax : q[MeanBits-1:0];
  endfunction

  // result register
  logic                valid_q;
  logic [MeanBits-1:0] ro_q, go_q, bo_q;
  logic [1:0]          so_q;
  logic                develop_ok;

  assign develop_ok = (op_q == OP_DEVELOP) && in_range && (c_old != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)               valid_q <= 1'b0;
    else if (cmd_i.out_load)   valid_q <= 1'b1;
    else if (out_ready_i)      valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      ro_q <= develop_ok ? sat_mean(rq_q) : '0;
      go_q <= develop_ok ? sat_mean(gq_q) : '0;
      bo_q <= develop_ok ? sat_mean(bq_q) : '0;
      if (op_q == OP_CLEAR)      so_q <= ST_OK;
      else if (!in_range)        so_q <= ST_RANGE;
      else if (op_q == OP_DEVELOP && c_old == '0) so_q <= ST_EMPTY;
      else                       so_q <= ST_OK;
    end
  end

  assign out_valid_o = valid_q;
  assign red_o       = ro_q;
  assign green_o     = go_q;
  assign blue_o      = bo_q;
  assign status_o    = so_q;

  assign sts_o.op         = op_q;
  assign sts_o.in_range   = in_range;
  assign sts_o.sweep_done = swp_q[AddrBits];
  assign sts_o.cnt_zero   = (c_old == '0);
  assign sts_o.div_done   = (dcnt_q == DivCntBits'(1));

endmodule

// ----- sv/pixel_sample_accumulation_buffer.sv -----
// Top level: stream ports, APB configuration registers, controller and datapath.
// Each item runs through the controller states in order: accumulate/merge READ, EXEC, OUT;
// out-of-range READ, OUT; develop READ, EXEC, DIV (40 quotient steps), OUT, with DIV skipped
// for a zero count; clear registers its result in READ; a waiting result holds the next one back.
// Throughput: one item at a time, the next taken once the result is registered; clear adds a sweep.
// Reset: registers return to 256x256 and a clearing sweep runs
// through the store, during which no item is accepted (configuration is taken).
module pixel_sample_accumulation_buffer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // tdata: operation[1:0], x_coord[9:2], y_coord[17:10], red_value[57:18],
  // green_value[97:58], blue_value[137:98], add_count[161:138], zero pad to 168
  input  logic [167:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // tdata: red_avg[23:0], green_avg[47:24], blue_avg[71:48], status[73:72], pad to 80
  output logic [79:0]   m_axis_tdata
);
  import psab_pkg::*;

  localparam logic [2:0] AddrWidth  = 3'd0;
  localparam logic [2:0] AddrHeight = 3'd4;

  logic [8:0] width_q, height_q;
  logic       wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
    end else if (wr) begin
      if (paddr == AddrWidth)  width_q  <= pwdata[8:0];
      if (paddr == AddrHeight) height_q <= pwdata[8:0];
    end
  end

  always_comb begin
    unique case (paddr)
      AddrWidth:  prdata = {23'd0, width_q};
      AddrHeight: prdata = {23'd0, height_q};
      default:    prdata = '0;
    endcase
  end

  cmd_t cmd;
  sts_t sts;
  logic out_valid;
  logic [MeanBits-1:0] r_avg, g_avg, b_avg;
  logic [1:0] status;

  // result register is busy while it holds an item not yet taken
  psab_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_busy_i (out_valid && !m_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  psab_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .width_i     (width_q),
    .height_i    (height_q),
    .op_i        (s_axis_tdata[1:0]),
    .x_i         (s_axis_tdata[9:2]),
    .y_i         (s_axis_tdata[17:10]),
    .red_i       (s_axis_tdata[57:18]),
    .green_i     (s_axis_tdata[97:58]),
    .blue_i      (s_axis_tdata[137:98]),
    .cnt_i       (s_axis_tdata[161:138]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (out_valid),
    .red_o       (r_avg),
    .green_o     (g_avg),
    .blue_o      (b_avg),
    .status_o    (status)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, status, b_avg, g_avg, r_avg};

endmodule
